// ===== rtl/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection block.
// Register index codes, register reset values, queue entry layout.
// No dependencies.
package dpb_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index codes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_DEPTH_SCALE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_ENABLE    = 3'd6;

  localparam int IMG_W_W   = 13;
  localparam int CENTER_W  = 16;
  localparam int INV_F_W   = 32;
  localparam int INV_DS_W  = 25;
  localparam int DEPTH_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int Z_W       = 32;
  localparam int POINT_W   = 48;
  localparam int COORD_W   = 12;

  localparam logic [IMG_W_W-1:0]  RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd3840;
  localparam logic [INV_F_W-1:0]  RST_INV_FOCAL_X     = 32'd8388608;
  localparam logic [INV_F_W-1:0]  RST_INV_FOCAL_Y     = 32'd8388608;
  localparam logic [INV_DS_W-1:0] RST_INV_DEPTH_SCALE = 25'd16777;

  // Decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [Z_W-1:0]     z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } dpb_entry_t;

endpackage

// ===== rtl/dpb_front.sv =====
// Front end: pixel acceptance, column/row tracking, depth scaling, zero-depth drop.
// Depends on dpb_pkg.
module dpb_front
  import dpb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                frame_start,
  input  logic [DEPTH_W-1:0]  depth_raw,
  input  logic [COLOR_W-1:0]  red_in,
  input  logic [COLOR_W-1:0]  green_in,
  input  logic [COLOR_W-1:0]  blue_in,
  input  logic [IMG_W_W-1:0]  image_width,
  input  logic [INV_DS_W-1:0] inv_depth_scale,
  input  logic                color_enable,
  input  logic                q_full,
  output logic                q_push,
  output dpb_entry_t          q_entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PROD_W = DEPTH_W + INV_DS_W;

  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        u;
  logic [RW-1:0]        v;
  logic [IMG_W_W-1:0]   width_eff;
  logic [IMG_W_W-1:0]   u_inc;
  logic [RW:0]          v_inc;
  logic                 accept;

  logic                 s1_vld_r;
  logic [PROD_W-1:0]    prod_r;
  logic [COORD_W-1:0]   u_r, v_r;
  logic [COLOR_W-1:0]   red_r, green_r, blue_r;

  logic [PROD_W:0]      z_rnd;
  logic [Z_W-1:0]       z;
  logic                 z_zero;

  assign accept = in_valid && in_ready;

  always_comb begin
    u = frame_start ? '0 : col_r;
    v = frame_start ? '0 : row_r;
    if (image_width == '0) begin
      width_eff = IMG_W_W'(1);
    end else if (image_width > IMG_W_W'(MAX_WIDTH)) begin
      width_eff = IMG_W_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    u_inc = IMG_W_W'(u) + IMG_W_W'(1);
    v_inc = {1'b0, v} + (RW+1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (u_inc >= width_eff) begin
        col_nxt = '0;
        row_nxt = (v_inc >= (RW+1)'(MAX_HEIGHT)) ? '0 : v_inc[RW-1:0];
      end else begin
        col_nxt = u_inc[CW-1:0];
        row_nxt = v;
      end
    end
  end

  // z = (raw * scale + 128) >> 8, saturated to 32 bits
  always_comb begin
    z_rnd  = {1'b0, prod_r} + (PROD_W+1)'(128);
    z      = (|z_rnd[PROD_W:Z_W+8]) ? '1 : z_rnd[Z_W+7:8];
    z_zero = (z == '0);
  end

  assign in_ready = !s1_vld_r || z_zero || !q_full;
  assign q_push   = s1_vld_r && !z_zero && !q_full;

  always_comb begin
    q_entry.col   = u_r;
    q_entry.row   = v_r;
    q_entry.z     = z;
    q_entry.red   = red_r;
    q_entry.green = green_r;
    q_entry.blue  = blue_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r  <= PROD_W'(depth_raw) * PROD_W'(inv_depth_scale);
      u_r     <= COORD_W'(u);
      v_r     <= COORD_W'(v);
      red_r   <= color_enable ? red_in   : '0;
      green_r <= color_enable ? green_in : '0;
      blue_r  <= color_enable ? blue_in  : '0;
    end
  end

  // A frame start puts the pixel at column 0 of row 0, so counters land just past it.
  a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_start |=>
      (col_r == CW'(1) && row_r == '0) || (col_r == '0 && row_r == RW'(1)))
    else $error("counters wrong after frame start");

endmodule

// ===== rtl/dpb_queue.sv =====
// Short FIFO that decouples the front end from the projection pipeline.
// Depends on dpb_pkg.
module dpb_queue
  import dpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dpb_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output dpb_entry_t head
);

  dpb_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QDEPTH) &&
    (count_r == (QPTR_W+1)'(QDEPTH) || wr_ptr_r - rd_ptr_r == count_r[QPTR_W-1:0]))
    else $error("queue occupancy inconsistent with pointers");

endmodule

// ===== rtl/dpb_back.sv =====
// Projection pipeline: x and y from column/row offset, depth and focal reciprocals.
// Five stalling stages; the last one is the result register. Depends on dpb_pkg.
module dpb_back
  import dpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dpb_entry_t          q_head,
  output logic                q_pop,
  input  logic [CENTER_W-1:0] center_x,
  input  logic [CENTER_W-1:0] center_y,
  input  logic [INV_F_W-1:0]  inv_focal_x,
  input  logic [INV_F_W-1:0]  inv_focal_y,
  output logic                res_valid,
  input  logic                res_pop,
  output logic [POINT_W-1:0]  point_x,
  output logic [POINT_W-1:0]  point_y,
  output logic [Z_W-1:0]      point_z,
  output logic [COLOR_W-1:0]  red_out,
  output logic [COLOR_W-1:0]  green_out,
  output logic [COLOR_W-1:0]  blue_out
);

  localparam int NSTG  = 5;
  localparam int NLANE = 2;          // lane 0: x, lane 1: y
  localparam int D_W   = CENTER_W + 1;
  localparam int P_W   = CENTER_W + Z_W;
  localparam int LO_W  = 2 * INV_F_W;
  localparam int HI_W  = (P_W - INV_F_W) + INV_F_W;
  localparam int S_W   = HI_W + 1;
  localparam logic [S_W-1:0] POS_LIM = S_W'(48'h7FFF_FFFF_FFFF);

  logic [NSTG-1:0]     vld_r;
  logic [NSTG:0]       rdy;
  logic [Z_W-1:0]      z_r   [NSTG];
  logic [COLOR_W-1:0]  red_r [NSTG];
  logic [COLOR_W-1:0]  grn_r [NSTG];
  logic [COLOR_W-1:0]  blu_r [NSTG];
  logic [NLANE-1:0]    neg_r [NSTG];

  logic [CENTER_W-1:0] mag_r [NLANE];
  logic [P_W-1:0]      p_r   [NLANE];
  logic [LO_W-1:0]     lo_r  [NLANE];
  logic [HI_W-1:0]     hi_r  [NLANE];
  logic [S_W-1:0]      sum_r [NLANE];
  logic [POINT_W-1:0]  res_r [NLANE];

  logic [COORD_W-1:0]  pos    [NLANE];
  logic [CENTER_W-1:0] ctr    [NLANE];
  logic [INV_F_W-1:0]  inv    [NLANE];
  logic signed [D_W-1:0] d    [NLANE];
  logic [CENTER_W-1:0] mag_nxt [NLANE];
  logic [NLANE-1:0]    neg_nxt;
  logic [S_W-1:0]      m      [NLANE];
  logic [POINT_W-1:0]  res_nxt [NLANE];

  // Stall chain from the result register back to the queue
  always_comb begin
    rdy[NSTG] = res_pop;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign q_pop = q_valid && rdy[0];

  always_comb begin
    pos[0] = q_head.col;
    pos[1] = q_head.row;
    ctr[0] = center_x;
    ctr[1] = center_y;
    inv[0] = inv_focal_x;
    inv[1] = inv_focal_y;
    for (int l = 0; l < NLANE; l++) begin
      d[l] = $signed({1'b0, pos[l], 4'b0000}) - $signed({1'b0, ctr[l]});
      neg_nxt[l] = d[l][D_W-1];
      mag_nxt[l] = neg_nxt[l] ? CENTER_W'(-d[l]) : CENTER_W'(d[l]);
      // rounded magnitude, then sign and clamp to 48 bits
      m[l] = {4'b0000, sum_r[l][S_W-1:4]};
      if (neg_r[3][l]) begin
        res_nxt[l] = (m[l] > POS_LIM + S_W'(1)) ? {1'b1, {(POINT_W-1){1'b0}}}
                                                 : POINT_W'(S_W'(0) - m[l]);
      end else begin
        res_nxt[l] = (m[l] > POS_LIM) ? {1'b0, {(POINT_W-1){1'b1}}} : m[l][POINT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= q_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      z_r[0]   <= q_head.z;
      red_r[0] <= q_head.red;
      grn_r[0] <= q_head.green;
      blu_r[0] <= q_head.blue;
      neg_r[0] <= neg_nxt;
      for (int l = 0; l < NLANE; l++) begin
        mag_r[l] <= mag_nxt[l];
      end
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        z_r[k]   <= z_r[k-1];
        red_r[k] <= red_r[k-1];
        grn_r[k] <= grn_r[k-1];
        blu_r[k] <= blu_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
    for (int l = 0; l < NLANE; l++) begin
      if (rdy[1]) begin
        p_r[l] <= P_W'(mag_r[l]) * P_W'(z_r[0]);
      end
      if (rdy[2]) begin
        lo_r[l] <= LO_W'(p_r[l][INV_F_W-1:0]) * LO_W'(inv[l]);
        hi_r[l] <= HI_W'(p_r[l][P_W-1:INV_F_W]) * HI_W'(inv[l]);
      end
      if (rdy[3]) begin
        sum_r[l] <= S_W'(hi_r[l]) + S_W'(lo_r[l][LO_W-1:INV_F_W]) + S_W'(8);
      end
      if (rdy[4]) begin
        res_r[l] <= res_nxt[l];
      end
    end
  end

  assign res_valid = vld_r[NSTG-1];
  assign point_x   = res_r[0];
  assign point_y   = res_r[1];
  assign point_z   = z_r[NSTG-1];
  assign red_out   = red_r[NSTG-1];
  assign green_out = grn_r[NSTG-1];
  assign blue_out  = blu_r[NSTG-1];

  // Zero-depth pixels are dropped in the front end and never reach the output.
  a_no_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> point_z != '0)
    else $error("result with zero depth");

  // A stalled result register must not be overwritten.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_pop |=> res_valid && $stable(point_x) && $stable(point_z))
    else $error("result changed while stalled");

endmodule

// ===== rtl/depth_pixel_backprojection_unit.sv =====
// Depth pixel back-projection unit: 16-bit depth raster in, 3-D points with color out.
// Path to the outputs: front scaling register, the queue, then the five projection stages.
// Throughput: one pixel per cycle while results are popped; the five-stage projection
// pipeline and the front scaling stage each take one pixel per cycle, with a 4-entry queue between.
// Reset (rst_n low, synchronous): registers take their default values, counters
// go to column 0 / row 0, queue and pipeline empty.
module depth_pixel_backprojection_unit
  import dpb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic                  in_frame_start,
  input  logic [DEPTH_W-1:0]    in_depth_raw,
  input  logic [COLOR_W-1:0]    in_red_in,
  input  logic [COLOR_W-1:0]    in_green_in,
  input  logic [COLOR_W-1:0]    in_blue_in,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  output logic [Z_W-1:0]        out_point_z,
  output logic [COLOR_W-1:0]    out_red_out,
  output logic [COLOR_W-1:0]    out_green_out,
  output logic [COLOR_W-1:0]    out_blue_out,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [IMG_W_W-1:0]  image_width_r;
  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic [INV_F_W-1:0]  inv_focal_x_r;
  logic [INV_F_W-1:0]  inv_focal_y_r;
  logic [INV_DS_W-1:0] inv_depth_scale_r;
  logic                color_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= RST_IMAGE_WIDTH;
      center_x_r        <= RST_CENTER_X;
      center_y_r        <= RST_CENTER_Y;
      inv_focal_x_r     <= RST_INV_FOCAL_X;
      inv_focal_y_r     <= RST_INV_FOCAL_Y;
      inv_depth_scale_r <= RST_INV_DEPTH_SCALE;
      color_enable_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata[IMG_W_W-1:0];
        REG_CENTER_X:        center_x_r        <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:        center_y_r        <= cfg_wdata[CENTER_W-1:0];
        REG_INV_FOCAL_X:     inv_focal_x_r     <= cfg_wdata[INV_F_W-1:0];
        REG_INV_FOCAL_Y:     inv_focal_y_r     <= cfg_wdata[INV_F_W-1:0];
        REG_INV_DEPTH_SCALE: inv_depth_scale_r <= cfg_wdata[INV_DS_W-1:0];
        REG_COLOR_ENABLE:    color_enable_r    <= cfg_wdata[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Front end -> queue -> projection pipeline
  logic       fe_ready;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       res_valid;
  dpb_entry_t q_in;
  dpb_entry_t q_head;

  logic [POINT_W-1:0] px, py;

  dpb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (push),
    .in_ready        (fe_ready),
    .frame_start     (in_frame_start),
    .depth_raw       (in_depth_raw),
    .red_in          (in_red_in),
    .green_in        (in_green_in),
    .blue_in         (in_blue_in),
    .image_width     (image_width_r),
    .inv_depth_scale (inv_depth_scale_r),
    .color_enable    (color_enable_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_in)
  );

  dpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  dpb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .inv_focal_x (inv_focal_x_r),
    .inv_focal_y (inv_focal_y_r),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .point_x     (px),
    .point_y     (py),
    .point_z     (out_point_z),
    .red_out     (out_red_out),
    .green_out   (out_green_out),
    .blue_out    (out_blue_out)
  );

  // full only while the front stage holds a nonzero-depth pixel the queue can't take
  assign full        = !fe_ready;
  assign empty       = !res_valid;
  assign out_point_x = $signed(px);
  assign out_point_y = $signed(py);

endmodule

// ===== tb/depth_pixel_backprojection_unit_tb.sv =====
// Self-checking testbench for depth_pixel_backprojection_unit: directed, scan and random pixels.
// Has its own back-projection predictor, with a result checker and randomly idling handshakes.
// Depends on rtl/dpb_pkg.sv and rtl/depth_pixel_backprojection_unit.sv.
`timescale 1ns / 1ps

module depth_pixel_backprojection_unit_tb;
  import dpb_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;

  // one expected point, same field widths as the result ports
  typedef struct {
    logic [POINT_W-1:0] x;
    logic [POINT_W-1:0] y;
    logic [Z_W-1:0]     z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } point_t;

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic                      in_frame_start;
  logic [DEPTH_W-1:0]        in_depth_raw;
  logic [COLOR_W-1:0]        in_red_in;
  logic [COLOR_W-1:0]        in_green_in;
  logic [COLOR_W-1:0]        in_blue_in;
  logic                      empty;
  logic                      pop;
  logic signed [POINT_W-1:0] out_point_x;
  logic signed [POINT_W-1:0] out_point_y;
  logic [Z_W-1:0]            out_point_z;
  logic [COLOR_W-1:0]        out_red_out;
  logic [COLOR_W-1:0]        out_green_out;
  logic [COLOR_W-1:0]        out_blue_out;
  logic                      cfg_we;
  logic [CFG_ADDR_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // shadow copy of the register file and the raster position
  logic [IMG_W_W-1:0]  cfg_image_width;
  logic [CENTER_W-1:0] cfg_center_x;
  logic [CENTER_W-1:0] cfg_center_y;
  logic [INV_F_W-1:0]  cfg_inv_focal_x;
  logic [INV_F_W-1:0]  cfg_inv_focal_y;
  logic [INV_DS_W-1:0] cfg_inv_depth_scale;
  logic                cfg_color_enable;
  logic [COORD_W-1:0]  col_pos;
  logic [COORD_W-1:0]  row_pos;

  point_t expected_points[$];  // points predicted but not yet popped
  point_t front_point;
  int     mismatches;
  bit     tx_idle_on;          // sender draws random gaps
  bit     rx_idle_on;          // receiver draws random gaps
  int     rx_gap;              // cycles left before the receiver pops again
  int     rx_hold_cycles;      // long receiver stall, counted down by the receiver

  depth_pixel_backprojection_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_frame_start (in_frame_start),
    .in_depth_raw   (in_depth_raw),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .empty          (empty),
    .pop            (pop),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // (pos*16 - center) * z * inv, Q.52 down to Q32.16, rounded half away from
  // zero on the magnitude, saturated to 48 bits signed
  function automatic logic [POINT_W-1:0] project_axis(input logic [COORD_W-1:0] pos,
                                                      input logic [CENTER_W-1:0] center,
                                                      input logic [Z_W-1:0] z,
                                                      input logic [INV_F_W-1:0] inv);
    logic [17:0]  pos_q4;
    logic [17:0]  ctr;
    logic [17:0]  mag;
    logic         neg;
    logic [113:0] prod;
    logic [113:0] m;
    logic [113:0] lim;
    pos_q4 = {2'b00, pos, 4'b0000};
    ctr    = {2'b00, center};
    neg    = pos_q4 < ctr;
    mag    = neg ? ctr - pos_q4 : pos_q4 - ctr;
    prod   = 114'(mag) * 114'(z) * 114'(inv);
    m      = (prod + (114'd1 << 35)) >> 36;
    lim    = (114'd1 << 47) - 114'd1;
    if (!neg) begin
      return (m > lim) ? {1'b0, {(POINT_W-1){1'b1}}} : m[POINT_W-1:0];
    end
    return (m > lim + 114'd1) ? {1'b1, {(POINT_W-1){1'b0}}}
                              : (~m[POINT_W-1:0]) + POINT_W'(1);
  endfunction

  // advance the raster position for one accepted pixel, queue its point if any
  function automatic void backproject_pixel(input logic fs, input logic [DEPTH_W-1:0] depth,
                                            input logic [COLOR_W-1:0] r,
                                            input logic [COLOR_W-1:0] g,
                                            input logic [COLOR_W-1:0] b);
    logic [IMG_W_W-1:0] w;
    logic [47:0]        depth_w;
    logic [47:0]        scale_w;
    logic [47:0]        z_wide;
    logic [Z_W-1:0]     z;
    point_t             pt;
    w = cfg_image_width;
    if (w == 0) w = IMG_W_W'(1);
    if (w > IMG_W_W'(MAX_W)) w = IMG_W_W'(MAX_W);
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    depth_w = 48'(depth);
    scale_w = 48'(cfg_inv_depth_scale);
    z_wide  = (depth_w * scale_w + 48'd128) >> 8;
    z       = (z_wide > 48'hFFFF_FFFF) ? '1 : z_wide[Z_W-1:0];
    if (z != 0) begin
      pt.x     = project_axis(col_pos, cfg_center_x, z, cfg_inv_focal_x);
      pt.y     = project_axis(row_pos, cfg_center_y, z, cfg_inv_focal_y);
      pt.z     = z;
      pt.red   = cfg_color_enable ? r : '0;
      pt.green = cfg_color_enable ? g : '0;
      pt.blue  = cfg_color_enable ? b : '0;
      expected_points = {expected_points, pt};
    end
    // row end: column back to 0, row up by one, row wraps after the last one
    if ({1'b0, col_pos} + 13'd1 >= w) begin
      col_pos = '0;
      row_pos = ({1'b0, row_pos} + 13'd1 >= 13'(MAX_H)) ? '0 : row_pos + COORD_W'(1);
    end else begin
      col_pos = col_pos + COORD_W'(1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver pacing at the falling edge, checking at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [POINT_W-1:0] exp_val,
                             input logic [POINT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point: expected none, actual x=%h y=%h z=%h", $time,
                 out_point_x, out_point_y, out_point_z);
        mismatches++;
      end else begin
        front_point = expected_points.pop_front();
        check_field("point_x", front_point.x, out_point_x);
        check_field("point_y", front_point.y, out_point_y);
        check_field("point_z", POINT_W'(front_point.z), POINT_W'(out_point_z));
        check_field("red_out", POINT_W'(front_point.red), POINT_W'(out_red_out));
        check_field("green_out", POINT_W'(front_point.green), POINT_W'(out_green_out));
        check_field("blue_out", POINT_W'(front_point.blue), POINT_W'(out_blue_out));
      end
      rx_gap = rx_idle_on ? $urandom_range(0, 15) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and register writes; all tasks start and end at a falling edge
  // ---------------------------------------------------------------------------

  // one pixel transfer; push stays high on return so back-to-back pixels
  // never lower and raise it in the same step
  task automatic send_pixel(input logic fs, input logic [DEPTH_W-1:0] depth,
                            input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_frame_start <= fs;
    in_depth_raw   <= depth;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    push           <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    backproject_pixel(fs, depth, r, g, b);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [DEPTH_W-1:0] depth;
    case ($urandom_range(0, 19))
      0, 1:    depth = '0;
      2:       depth = '1;
      3:       depth = DEPTH_W'($urandom_range(1, 255));
      4:       depth = {1'b1, 15'($urandom_range(0, 32767))};
      default: depth = DEPTH_W'($urandom_range(0, 65535));
    endcase
    send_pixel($urandom_range(0, 63) == 0, depth, COLOR_W'($urandom_range(0, 255)),
               COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
  endtask

  // register write; the enable is lowered again before return so it drops between writes
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_IMAGE_WIDTH:     cfg_image_width     = val[IMG_W_W-1:0];
      REG_CENTER_X:        cfg_center_x        = val[CENTER_W-1:0];
      REG_CENTER_Y:        cfg_center_y        = val[CENTER_W-1:0];
      REG_INV_FOCAL_X:     cfg_inv_focal_x     = val[INV_F_W-1:0];
      REG_INV_FOCAL_Y:     cfg_inv_focal_y     = val[INV_F_W-1:0];
      REG_INV_DEPTH_SCALE: cfg_inv_depth_scale = val[INV_DS_W-1:0];
      REG_COLOR_ENABLE:    cfg_color_enable    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every predicted point, then let zero-depth pixels
  // still inside the pipeline drain
  task automatic settle();
    push <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset register values, no writes yet; color must come out zero
  task automatic test_reset_values();
    tx_idle_on = 1;
    rx_idle_on = 1;
    send_pixel(1'b1, 16'd1000, 8'hFF, 8'h00, 8'h80);
    send_pixel(1'b0, 16'd0, 8'h12, 8'h34, 8'h56);
    send_pixel(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 16'd1, 8'h01, 8'h02, 8'h03);
    settle();
  endtask

  // field and register extremes, z saturation, depth rounding to zero,
  // zero scale, width zero and oversized width
  task automatic test_extremes();
    write_reg(REG_IMAGE_WIDTH, 32'd3);
    write_reg(REG_CENTER_X, 32'd0);
    write_reg(REG_CENTER_Y, 32'd65535);
    write_reg(REG_INV_FOCAL_X, 32'hFFFF_FFFF);
    write_reg(REG_INV_FOCAL_Y, 32'hFFFF_FFFF);
    write_reg(REG_INV_DEPTH_SCALE, 32'h01FF_FFFF);  // above one: z saturates
    write_reg(REG_COLOR_ENABLE, 32'd1);
    send_pixel(1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 16'd0, 8'hAA, 8'h55, 8'hAA);
    send_pixel(1'b0, 16'hFFFF, 8'h55, 8'hAA, 8'h55);  // new row
    send_pixel(1'b0, 16'h8000, 8'h0F, 8'hF0, 8'h3C);
    settle();
    write_reg(REG_IMAGE_WIDTH, 32'd0);               // acts as one
    write_reg(REG_CENTER_X, 32'd65535);
    write_reg(REG_CENTER_Y, 32'd0);
    write_reg(REG_INV_FOCAL_X, 32'd0);
    write_reg(REG_INV_DEPTH_SCALE, 32'd1);
    write_reg(REG_COLOR_ENABLE, 32'd0);
    send_pixel(1'b0, 16'd1, 8'hFF, 8'hFF, 8'hFF);    // scaled depth rounds to zero
    send_pixel(1'b0, 16'd127, 8'hFF, 8'hFF, 8'hFF);  // still zero
    send_pixel(1'b0, 16'd128, 8'hFF, 8'hFF, 8'hFF);  // smallest nonzero z
    send_pixel(1'b0, 16'hFFFF, 8'h81, 8'h42, 8'h24);
    send_pixel(1'b1, 16'd300, 8'h11, 8'h22, 8'h33);
    settle();
    write_reg(REG_INV_DEPTH_SCALE, 32'd0);           // every pixel dropped
    send_pixel(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 16'd4660, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(REG_IMAGE_WIDTH, 32'hFFFF_FFFF);       // masked, then capped
    write_reg(REG_INV_DEPTH_SCALE, 32'h0100_0000);   // exactly one
    write_reg(REG_INV_FOCAL_X, 32'h8000_0000);
    send_pixel(1'b0, 16'd1, 8'h7F, 8'h7F, 8'h7F);
    send_pixel(1'b0, 16'hFFFF, 8'h80, 8'h80, 8'h80);
    settle();
  endtask

  // column wrap over a few narrow rows, and a frame start part way through a row
  task automatic test_column_wrap();
    logic [DEPTH_W-1:0] depth;
    write_reg(REG_IMAGE_WIDTH, 32'd33);
    write_reg(REG_INV_DEPTH_SCALE, 32'd16777);
    write_reg(REG_CENTER_X, $urandom_range(0, 65535));
    write_reg(REG_INV_FOCAL_X, $urandom);
    write_reg(REG_COLOR_ENABLE, 32'd1);
    tx_idle_on = 0;
    rx_idle_on = 0;
    for (int i = 0; i < 100; i++) begin
      depth = (i % 5 == 4) ? '0 : DEPTH_W'($urandom_range(1, 65535));
      send_pixel(i == 0 || i == 70, depth, COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
    end
    settle();
  endtask

  // width one: the row steps on every pixel and the column stays at zero
  task automatic test_row_step();
    write_reg(REG_IMAGE_WIDTH, 32'd1);
    write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
    write_reg(REG_INV_FOCAL_Y, $urandom);
    for (int i = 0; i < 64; i++) begin
      send_pixel(i == 0, DEPTH_W'($urandom_range(1, 65535)),
                 COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)));
    end
    settle();
  endtask

  // receiver stalls long enough for the queue and pipeline to fill and full
  // to rise while the sender keeps offering
  task automatic test_backpressure();
    write_reg(REG_IMAGE_WIDTH, 32'd16);
    tx_idle_on = 0;
    rx_idle_on = 1;
    rx_hold_cycles = 300;
    for (int i = 0; i < 80; i++) begin
      send_pixel(i == 0, DEPTH_W'($urandom_range(1, 65535)),
                 COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)));
    end
    settle();
  endtask

  // random register setting per phase, then a raster of random pixels
  task automatic test_random(input int phases, input int pixels_per_phase);
    logic [CFG_DATA_W-1:0] w;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 7))
        0: w = 32'd1;
        1: w = 32'd2;
        2: w = CFG_DATA_W'(MAX_W);
        3: w = 32'd0;
        4: w = 32'd8191;
        5: w = $urandom_range(3, 64);
        6: w = 32'd640;
        default: w = $urandom;
      endcase
      write_reg(REG_IMAGE_WIDTH, w);
      case ($urandom_range(0, 3))
        0: write_reg(REG_CENTER_X, 32'd0);
        1: write_reg(REG_CENTER_X, 32'd65535);
        2: write_reg(REG_CENTER_X, 32'({w[11:0], 3'b000}));  // middle of the row
        default: write_reg(REG_CENTER_X, $urandom);
      endcase
      write_reg(REG_CENTER_Y, ($urandom_range(0, 3) == 0) ? 32'd65535 : $urandom);
      write_reg(REG_INV_FOCAL_X, ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_INV_FOCAL_Y, ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom);
      case ($urandom_range(0, 5))
        0: write_reg(REG_INV_DEPTH_SCALE, 32'h0100_0000);
        1: write_reg(REG_INV_DEPTH_SCALE, 32'h01FF_FFFF);
        2: write_reg(REG_INV_DEPTH_SCALE, $urandom_range(1, 255));
        default: write_reg(REG_INV_DEPTH_SCALE, $urandom_range(1, 32'h0100_0000));
      endcase
      write_reg(REG_COLOR_ENABLE, $urandom);
      // first phase runs without idling on either side
      tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < pixels_per_phase; i++) send_random_pixel();
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    in_frame_start = 1'b0;
    in_depth_raw   = '0;
    in_red_in      = '0;
    in_green_in    = '0;
    in_blue_in     = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    mismatches     = 0;
    tx_idle_on     = 0;
    rx_idle_on     = 0;
    rx_gap         = 0;
    rx_hold_cycles = 0;
    // shadow starts at the reset values
    cfg_image_width     = RST_IMAGE_WIDTH;
    cfg_center_x        = RST_CENTER_X;
    cfg_center_y        = RST_CENTER_Y;
    cfg_inv_focal_x     = RST_INV_FOCAL_X;
    cfg_inv_focal_y     = RST_INV_FOCAL_Y;
    cfg_inv_depth_scale = RST_INV_DEPTH_SCALE;
    cfg_color_enable    = 1'b0;
    col_pos             = '0;
    row_pos             = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_extremes();
    test_column_wrap();
    test_row_step();
    test_backpressure();
    test_random(6, 200);

    settle();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("depth_pixel_backprojection_unit_tb OK");
    end else begin
      $display("depth_pixel_backprojection_unit_tb NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("depth_pixel_backprojection_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dpb_pkg.sv
rtl/dpb_front.sv
rtl/dpb_queue.sv
rtl/dpb_back.sv
rtl/depth_pixel_backprojection_unit.sv
tb/depth_pixel_backprojection_unit_tb.sv
